/* rtl/ipd_pkg.sv */
// Shared types and constants for the +IPD frame deframer.
package ipd_pkg;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_I     = 8'h49;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Header "+IPD," is five bytes long.
  localparam logic [2:0] HDR_LEN  = 3'd5;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic [15:0] payload_position;
    logic        end_of_message;
    logic        empty_message;
  } ipd_res_t;

  // Expected header byte at a given header position.
  function automatic logic [7:0] hdr_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = CH_PLUS;
      3'd1:    c = CH_I;
      3'd2:    c = CH_P;
      3'd3:    c = CH_D;
      3'd4:    c = CH_COMMA;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

/* rtl/ipd_parser.sv */
// Frame parser: header check, length decode and payload counting.
module ipd_parser #(
  parameter int LENGTH_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  logic [7:0]        in_byte,
  output logic              res_valid,
  output ipd_pkg::ipd_res_t res
);
  import ipd_pkg::*;

  typedef enum logic [1:0] {PH_IDLE, PH_HEADER, PH_LENGTH, PH_DATA} phase_t;

  localparam int PW = (LENGTH_BITS < 16) ? LENGTH_BITS : 16;

  phase_t                 phase_r, phase_nxt;
  logic [2:0]             hcnt_r, hcnt_nxt;
  logic                   mism_r, mism_nxt;
  logic [LENGTH_BITS-1:0] len_r, len_nxt;
  logic [LENGTH_BITS-1:0] cnt_r, cnt_nxt;
  logic [LENGTH_BITS+3:0] prod;
  logic [3:0]             digit;
  logic [7:0]             digit_full;

  assign digit_full = in_byte - CH_ZERO;
  assign digit      = digit_full[3:0];
  assign prod = {1'b0, len_r, 3'b000} + {3'b000, len_r, 1'b0}
              + {{LENGTH_BITS{1'b0}}, digit};

  always_comb begin
    phase_nxt = phase_r;
    hcnt_nxt  = hcnt_r;
    mism_nxt  = mism_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    res_valid = 1'b0;
    res       = '0;
    if (in_fire) begin
      case (phase_r)
        PH_IDLE: begin
          if (in_byte == CH_PLUS) begin
            hcnt_nxt  = 3'd1;
            mism_nxt  = 1'b0;
            phase_nxt = PH_HEADER;
          end
        end
        PH_HEADER: begin
          mism_nxt = mism_r | (in_byte != hdr_char(hcnt_r));
          hcnt_nxt = hcnt_r + 3'd1;
          if (hcnt_nxt == HDR_LEN) begin
            if (mism_nxt) begin
              phase_nxt = PH_IDLE;
            end else begin
              len_nxt   = '0;
              phase_nxt = PH_LENGTH;
            end
          end
        end
        PH_LENGTH: begin
          if (in_byte >= CH_ZERO && in_byte <= CH_NINE) begin
            // saturate once the product leaves the length range
            if (prod[LENGTH_BITS+3:LENGTH_BITS] != 4'd0) begin
              len_nxt = '1;
            end else begin
              len_nxt = prod[LENGTH_BITS-1:0];
            end
          end else if (in_byte == CH_COLON) begin
            cnt_nxt   = '0;
            phase_nxt = PH_DATA;
          end
        end
        PH_DATA: begin
          res_valid = 1'b1;
          if (len_r == '0) begin
            res.end_of_message = 1'b1;
            res.empty_message  = 1'b1;
            phase_nxt          = PH_IDLE;
          end else begin
            res.payload_byte     = in_byte;
            res.payload_position = 16'(cnt_r[PW-1:0]);
            cnt_nxt              = cnt_r + 1'b1;
            if (cnt_nxt == len_r) begin
              res.end_of_message = 1'b1;
              len_nxt            = '0;
              phase_nxt          = PH_IDLE;
            end
          end
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      hcnt_r  <= 3'd0;
      mism_r  <= 1'b0;
      len_r   <= '0;
      cnt_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      hcnt_r  <= hcnt_nxt;
      mism_r  <= mism_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

/* rtl/ipd_out_reg.sv */
// Result register between the parser and the output channel.
module ipd_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  logic              res_valid,
  input  ipd_pkg::ipd_res_t res,
  input  logic              out_ready,
  output logic              out_valid,
  output ipd_pkg::ipd_res_t out_res,
  output logic              can_load
);
  import ipd_pkg::*;

  logic     valid_r, valid_nxt;
  ipd_res_t res_r;

  // free when empty or draining this cycle
  assign can_load = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (in_fire) begin
      valid_nxt = res_valid;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

/* rtl/ipd_frame_deframer.sv */
// Top level of the +IPD frame deframer: parser plus result register.
// A payload request is registered and shows on the output in the cycle after it is accepted.
// Throughput: one received byte per cycle while no held result stalls it; the parser
//   state update is a single pass of logic, and the result register refills while it drains.
// Reset: synchronous, active low; returns the parser to idle and empties
//   the result register. No clearing pass is needed.
module ipd_frame_deframer #(
  parameter int LENGTH_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_payload_byte,
  output logic [15:0] out_payload_position,
  output logic        out_end_of_message,
  output logic        out_empty_message
);
  import ipd_pkg::*;

  logic     in_fire;
  logic     res_valid;
  ipd_res_t res;
  ipd_res_t out_res;
  logic     can_load;

  // Take a new byte whenever the result register is free or being drained;
  // bytes that cause no result still advance the parser.
  assign in_ready = can_load;
  assign in_fire  = in_valid && in_ready;

  ipd_parser #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_byte   (in_rx_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  // Hold the finished request until the consumer takes it.
  ipd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .res_valid (res_valid),
    .res       (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_res   (out_res),
    .can_load  (can_load)
  );

  assign out_payload_byte     = out_res.payload_byte;
  assign out_payload_position = out_res.payload_position;
  assign out_end_of_message   = out_res.end_of_message;
  assign out_empty_message    = out_res.empty_message;

  // An empty message is always the last and carries no byte.
  a_empty_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_empty_message |->
      out_end_of_message && out_payload_byte == 8'd0 && out_payload_position == 16'd0)
    else $error("empty message result malformed");

  // Never overwrite a stalled result.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && out_valid |-> out_ready)
    else $error("result register overwritten while stalled");

  // An empty result register must not block input.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

endmodule

/* tb/sv/tb_top.sv */
// Testbench for the +IPD frame deframer: directed frames, back-pressure, a saturated length, and random traffic.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ipd_pkg::*;

  // Parser phases of the predictor; encoded the same way as the block's own phases.
  typedef enum logic [1:0] {
    ST_WAIT_PLUS,
    ST_HEADER,
    ST_LENGTH,
    ST_PAYLOAD
  } parse_state_t;

  localparam int unsigned RUN_LIMIT_NS      = 3_000_000;
  localparam int unsigned HOLD_CYCLES       = 300;
  localparam int unsigned RANDOM_TARGET     = 280;
  localparam int unsigned SAT_PAYLOAD_BYTES = 200;
  localparam logic [15:0] LENGTH_SAT        = 16'hFFFF;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_valid   = 1'b0;
  logic        in_ready;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready  = 1'b0;
  logic [7:0]  out_payload_byte;
  logic [15:0] out_payload_position;
  logic        out_end_of_message;
  logic        out_empty_message;

  // Idle and stall odds, in percent per cycle.
  int unsigned in_idle_pct   = 0;
  int unsigned out_stall_pct = 0;

  // Long receiver hold-off: the test raises the request, the ready process counts it down.
  logic        hold_request = 1'b0;
  int unsigned hold_left    = 0;

  int unsigned mismatch_count = 0;
  int unsigned frame_bytes    = 0;

  // Predictor state.
  parse_state_t pred_state    = ST_WAIT_PLUS;
  logic [2:0]   pred_hdr_count = 3'd0;
  logic         pred_hdr_bad   = 1'b0;
  logic [15:0]  pred_msg_len   = 16'd0;
  logic [15:0]  pred_byte_cnt  = 16'd0;
  logic [7:0]   header_text [5] = '{CH_PLUS, CH_I, CH_P, CH_D, CH_COMMA};

  // Payload results still owed by the block, oldest first.
  ipd_res_t payload_expect_q [$];

  ipd_frame_deframer #(.LENGTH_BITS(16)) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_rx_byte          (in_rx_byte),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_payload_byte    (out_payload_byte),
    .out_payload_position(out_payload_position),
    .out_end_of_message  (out_end_of_message),
    .out_empty_message   (out_empty_message)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Advance the deframer's state by one accepted byte and queue the result it owes, if any.
  function automatic void deframe_rx_byte(input logic [7:0] b);
    logic [31:0] acc;
    ipd_res_t    res;
    res = '0;
    case (pred_state)
      ST_WAIT_PLUS: if (b == CH_PLUS) begin
        pred_state     = ST_HEADER;
        pred_hdr_count = 3'd1;
        pred_hdr_bad   = 1'b0;
      end
      ST_HEADER: begin
        if (pred_hdr_count < HDR_LEN) begin
          if (b != header_text[pred_hdr_count]) pred_hdr_bad = 1'b1;
          pred_hdr_count = pred_hdr_count + 3'd1;
        end
        // All five header bytes seen: either give up or start on the length.
        if (pred_hdr_count >= HDR_LEN) begin
          if (pred_hdr_bad) begin
            pred_state = ST_WAIT_PLUS;
          end else begin
            pred_msg_len = '0;
            pred_state   = ST_LENGTH;
          end
        end
      end
      ST_LENGTH: if (b >= CH_ZERO && b <= CH_NINE) begin
        // Accumulate the decimal length, clamping at the top of the counter.
        acc = 32'(pred_msg_len) * 32'd10 + 32'(b - CH_ZERO);
        pred_msg_len = (acc > 32'(LENGTH_SAT)) ? LENGTH_SAT : acc[15:0];
      end else if (b == CH_COLON) begin
        pred_byte_cnt = '0;
        pred_state    = ST_PAYLOAD;
      end
      ST_PAYLOAD: begin
        if (pred_msg_len == '0) begin
          // Empty message: swallow one byte and report it as an empty completion.
          res.end_of_message = 1'b1;
          res.empty_message  = 1'b1;
          pred_state         = ST_WAIT_PLUS;
        end else begin
          res.payload_byte     = b;
          res.payload_position = pred_byte_cnt;
          pred_byte_cnt        = pred_byte_cnt + 16'd1;
          if (pred_byte_cnt == pred_msg_len) begin
            res.end_of_message = 1'b1;
            pred_state         = ST_WAIT_PLUS;
            pred_msg_len       = '0;
          end
        end
        payload_expect_q.push_back(res);
      end
      default: pred_state = ST_WAIT_PLUS;
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $time, what);
    mismatch_count++;
  endtask

  // Compare one delivered request with the oldest queued result, field by field.
  task automatic check_payload_result();
    ipd_res_t want;
    if (payload_expect_q.size() == 0) begin
      report_mismatch($sformatf("unexpected result byte=%02h pos=%0d eom=%0b empty=%0b",
                                out_payload_byte, out_payload_position,
                                out_end_of_message, out_empty_message));
    end else begin
      want = payload_expect_q.pop_front();
      if (out_payload_byte !== want.payload_byte)
        report_mismatch($sformatf("payload_byte %02h, want %02h",
                                  out_payload_byte, want.payload_byte));
      if (out_payload_position !== want.payload_position)
        report_mismatch($sformatf("payload_position %0d, want %0d",
                                  out_payload_position, want.payload_position));
      if (out_end_of_message !== want.end_of_message)
        report_mismatch($sformatf("end_of_message %0b, want %0b",
                                  out_end_of_message, want.end_of_message));
      if (out_empty_message !== want.empty_message)
        report_mismatch($sformatf("empty_message %0b, want %0b",
                                  out_empty_message, want.empty_message));
    end
  endtask

  // Sample both channels at the rising edge: predict from the accepted byte first, so an
  // expectation is always queued before the result it describes could be checked.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) deframe_rx_byte(in_rx_byte);
      if (out_valid && out_ready) check_payload_result();
    end
  end

  // Drive ready at the falling edge; a pending hold-off request overrides the random stalls.
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  // Offer one byte, idling first at random, and hold it until the block takes it.
  // Enter and leave at a falling edge; valid stays high so back-to-back bytes need no toggle.
  task automatic send_rx_byte(input logic [7:0] b);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_rx_byte(s[i]);
  endtask

  // Any byte the length field ignores: not a digit and not the colon.
  function automatic logic [7:0] length_junk();
    logic [7:0] b;
    do b = 8'($urandom_range(255));
    while ((b >= CH_ZERO && b <= CH_NINE) || b == CH_COLON);
    return b;
  endfunction

  // Send a full frame; a messy one carries leading zeros and junk inside the length.
  task automatic send_frame(input int unsigned len, input bit messy);
    string digits;
    digits = $sformatf("%0d", len);
    for (int i = 0; i < HDR_LEN; i++) send_rx_byte(header_text[i]);
    if (messy) repeat ($urandom_range(2)) send_rx_byte(CH_ZERO);
    for (int i = 0; i < digits.len(); i++) begin
      if (messy && $urandom_range(2) == 0) send_rx_byte(length_junk());
      send_rx_byte(digits[i]);
    end
    send_rx_byte(CH_COLON);
    // A zero-length frame still consumes one byte after the colon.
    for (int i = 0; i < ((len == 0) ? 1 : len); i++) send_rx_byte(8'($urandom_range(255)));
    frame_bytes += HDR_LEN + digits.len() + 1 + ((len == 0) ? 1 : len);
  endtask

  // Send a header with one wrong byte after the plus; the block drops back to idle.
  task automatic send_broken_header();
    int unsigned bad_pos;
    logic [7:0]  b;
    bad_pos = $urandom_range(HDR_LEN - 1, 1);
    for (int i = 0; i < HDR_LEN; i++) begin
      b = header_text[i];
      if (i == bad_pos) begin
        do b = 8'($urandom_range(255));
        while (b == header_text[i]);
      end
      send_rx_byte(b);
    end
    frame_bytes += HDR_LEN;
  endtask

  function automatic int unsigned random_length();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return 0;
    if (r < 85) return $urandom_range(12, 1);
    return $urandom_range(60, 13);
  endfunction

  // Drop valid and hold the sender until every queued result has come out.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(negedge clk);
    while (payload_expect_q.size() != 0);
  endtask

  task automatic set_idling(input int unsigned idle_pct, input int unsigned stall_pct);
    in_idle_pct   = idle_pct;
    out_stall_pct = stall_pct;
  endtask

  // Short hand-built frames: leading zero and junk in the length, byte extremes,
  // a length with no digits, a plus inside the payload, and a plus inside the header.
  task automatic test_directed();
    set_idling(0, 0);
    send_text("+IPD,0a2:");
    send_rx_byte(8'hFF);
    send_rx_byte(8'h00);
    send_text("+IPD,:");
    send_rx_byte(CH_PLUS);
    send_text("+I+D,");
    wait_for_drain();
  endtask

  // Overflow the length twice so it clamps at its maximum, then stream the head of the
  // payload; no early end may show. Run last, since the message never completes.
  task automatic test_length_saturation();
    set_idling(0, 0);
    send_text("+IPD,655360:");
    for (int i = 0; i < SAT_PAYLOAD_BYTES; i++) send_rx_byte(8'($urandom_range(255)));
    wait_for_drain();
  endtask

  // Hold off the receiver for a long stretch while the sender keeps offering a frame,
  // so the result register fills and the input stalls; then pause until all drained.
  task automatic test_backpressure();
    set_idling(0, 0);
    hold_request = 1'b1;
    send_frame(40, 1'b0);
    send_frame(0, 1'b0);
    wait_for_drain();
  endtask

  // Mostly well-formed frames with random content; the rest broken headers and line noise.
  task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct);
    int unsigned start;
    int unsigned pick;
    set_idling(idle_pct, stall_pct);
    start = frame_bytes;
    while (frame_bytes - start < RANDOM_TARGET) begin
      pick = $urandom_range(99);
      if (pick < 75) send_frame(random_length(), $urandom_range(3) == 0);
      else if (pick < 88) send_broken_header();
      else send_rx_byte(8'($urandom_range(255)));
    end
    wait_for_drain();
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_backpressure();
    test_random_traffic(0, 0);
    test_random_traffic(85, 0);
    test_random_traffic(0, 85);
    test_random_traffic(33, 33);
    test_length_saturation();

    // Let any stray request surface before judging.
    repeat (4) @(negedge clk);
    if (mismatch_count == 0 && payload_expect_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("TB_ERROR");
    $finish;
  end

endmodule
